FILE: hdl/smallest_padding_run_finder_defines.svh
// Assertion macros used by the checker.
`ifndef SMALLEST_PADDING_RUN_FINDER_DEFINES_SVH
`define SMALLEST_PADDING_RUN_FINDER_DEFINES_SVH

// cond must never hold outside reset
`define SPRF_ASSERT_NEVER(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

// same-cycle implication
`define SPRF_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define SPRF_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: hdl/sprf_pkg.sv
package sprf_pkg;

   localparam int CSR_INDEX_W = 2;

   localparam logic [CSR_INDEX_W-1:0] CSR_MIN_RUN_LEN         = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_REQUIRED_ATTRIBUTES = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_GROW_ALIGN          = 2'd2;

   localparam logic [7:0]  FILL_ZERO = 8'h00;
   localparam logic [7:0]  FILL_TRAP = 8'hCC;
   localparam logic [31:0] ALL_ONES  = 32'hFFFF_FFFF;

   localparam logic [31:0] RESET_MIN_RUN_LEN         = 32'd1;
   localparam logic [31:0] RESET_REQUIRED_ATTRIBUTES = 32'd0;
   localparam logic [31:0] RESET_ALIGN_MASK          = 32'd4095;

   typedef struct packed {
      logic [7:0]  data_byte;
      logic [6:0]  section_index;
      logic [31:0] section_attributes;
      logic [31:0] section_virtual_size;
      logic        last_of_section;
      logic        last_of_image;
   } sprf_req_type;

   typedef struct packed {
      logic        found;
      logic [6:0]  cave_section;
      logic [31:0] cave_start;
      logic [31:0] cave_length;
      logic        needs_growth;
      logic [31:0] new_virtual_size;
   } sprf_rsp_type;

   typedef struct packed {
      logic        fill;
      logic [7:0]  data_byte;
      logic [6:0]  section_index;
      logic [31:0] section_virtual_size;
      logic        last_of_section;
      logic        last_of_image;
   } sprf_item_type;

   typedef struct packed {
      logic [31:0] min_run_len;
      logic [31:0] required_attributes;
      logic [31:0] align_mask;
   } sprf_cfg_type;

   typedef struct packed {
      logic        active;
      logic [7:0]  value;
      logic [31:0] start;
      logic [31:0] length;
      logic [6:0]  section;
      logic [31:0] vsize;
   } sprf_run_type;

   typedef struct packed {
      logic        have;
      logic [31:0] length;
      logic [31:0] offset;
      logic [6:0]  section;
      logic [31:0] vsize;
   } sprf_best_type;

   localparam sprf_run_type RUN_CLEAR = '{
      active: 1'b0, value: 8'd0, start: 32'd0, length: 32'd0, section: 7'd0, vsize: 32'd0};

   localparam sprf_best_type BEST_CLEAR = '{
      have: 1'b0, length: ALL_ONES, offset: 32'd0, section: 7'd0, vsize: 32'd0};

   function automatic sprf_best_type close_best(input sprf_run_type run,
                                                input sprf_best_type best,
                                                input logic [31:0] min_run_len);
      sprf_best_type result;
      result = best;
      if (run.active && run.length >= min_run_len && run.length < best.length) begin
         result.have    = 1'b1;
         result.length  = run.length;
         result.offset  = run.start;
         result.section = run.section;
         result.vsize   = run.vsize;
      end
      return result;
   endfunction

endpackage

FILE: hdl/sprf_fifo.sv
module sprf_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] wdata,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] rdata,
   output logic             empty
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full    = (count_ff == CNT_W'(DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rdata   = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= wdata;
      end
   end

endmodule

FILE: hdl/sprf_front.sv
module sprf_front
   import sprf_pkg::*;
(
   input  logic          req_push,
   input  sprf_req_type  req_data,
   output logic          req_full,
   input  sprf_cfg_type  cfg,
   input  logic          queue_full,
   output logic          queue_push,
   output sprf_item_type queue_item
);

   logic accepted;
   logic padding;

   assign accepted = (cfg.required_attributes == '0) ||
                     ((req_data.section_attributes & cfg.required_attributes) ==
                      cfg.required_attributes);
   assign padding  = (req_data.data_byte == FILL_ZERO) || (req_data.data_byte == FILL_TRAP);

   assign req_full   = queue_full;
   assign queue_push = req_push;

   always_comb begin
      queue_item.fill                 = accepted && padding;
      queue_item.data_byte            = req_data.data_byte;
      queue_item.section_index        = req_data.section_index;
      queue_item.section_virtual_size = req_data.section_virtual_size;
      queue_item.last_of_section      = req_data.last_of_section;
      queue_item.last_of_image        = req_data.last_of_image;
   end

endmodule

FILE: hdl/sprf_back.sv
module sprf_back
   import sprf_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  sprf_cfg_type  cfg,
   input  logic          item_valid,
   input  sprf_item_type item,
   output logic          item_pop,
   output logic          snap_valid,
   input  logic          snap_ready,
   output sprf_best_type snap_data
);

   sprf_run_type  run_ff, run_in, run_v;
   sprf_best_type best_ff, best_in, best_v;
   logic [31:0]   offset_ff, offset_in;
   logic          fire;

   assign fire     = item_valid && (!item.last_of_image || snap_ready);
   assign item_pop = fire;

   always_comb begin
      run_v      = run_ff;
      best_v     = best_ff;
      run_in     = run_ff;
      best_in    = best_ff;
      offset_in  = offset_ff;
      snap_valid = 1'b0;
      snap_data  = best_ff;
      if (fire) begin
         // end the current run on a value change or a non-padding byte
         if (run_v.active && (!item.fill || item.data_byte != run_v.value)) begin
            best_v        = close_best(run_v, best_v, cfg.min_run_len);
            run_v.active  = 1'b0;
         end
         if (item.fill) begin
            if (!run_v.active) begin
               run_v.active  = 1'b1;
               run_v.value   = item.data_byte;
               run_v.start   = offset_ff;
               run_v.length  = '0;
               run_v.section = item.section_index;
               run_v.vsize   = item.section_virtual_size;
            end
            if (run_v.length != ALL_ONES) begin
               run_v.length = run_v.length + 32'd1;
            end
         end
         if (item.last_of_section || item.last_of_image) begin
            best_v       = close_best(run_v, best_v, cfg.min_run_len);
            run_v.active = 1'b0;
            offset_in    = '0;
         end else begin
            offset_in = offset_ff + 32'd1;
         end
         if (item.last_of_image) begin
            snap_valid = 1'b1;
            snap_data  = best_v;
            run_in     = RUN_CLEAR;
            best_in    = BEST_CLEAR;
         end else begin
            run_in  = run_v;
            best_in = best_v;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff    <= RUN_CLEAR;
         best_ff   <= BEST_CLEAR;
         offset_ff <= '0;
      end else begin
         run_ff    <= run_in;
         best_ff   <= best_in;
         offset_ff <= offset_in;
      end
   end

endmodule

FILE: hdl/sprf_finish.sv
module sprf_finish
   import sprf_pkg::*;
#(
   parameter int RSP_DEPTH = 2
) (
   input  logic          clock,
   input  logic          reset,
   input  sprf_cfg_type  cfg,
   input  logic          snap_valid,
   output logic          snap_ready,
   input  sprf_best_type snap_data,
   input  logic          rsp_pop,
   output logic          rsp_empty,
   output sprf_rsp_type  rsp_data
);

   sprf_best_type hold_ff;
   logic          hold_valid_ff, hold_valid_in;
   logic          out_full;
   logic          drain;
   logic          load;
   logic [31:0]   end_sum;
   logic          grow;
   sprf_rsp_type  result;
   logic [$bits(sprf_rsp_type)-1:0] out_rdata;

   assign drain      = hold_valid_ff && !out_full;
   assign snap_ready = !hold_valid_ff || !out_full;
   assign load       = snap_valid && snap_ready;

   assign end_sum = hold_ff.offset + cfg.min_run_len;
   assign grow    = end_sum > hold_ff.vsize;

   always_comb begin
      result = '0;
      if (hold_ff.have) begin
         result.found            = 1'b1;
         result.cave_section     = hold_ff.section;
         result.cave_start       = hold_ff.offset;
         result.cave_length      = hold_ff.length;
         result.needs_growth     = grow;
         result.new_virtual_size = grow ? ((end_sum + cfg.align_mask) & ~cfg.align_mask)
                                        : hold_ff.vsize;
      end
   end

   always_comb begin
      hold_valid_in = hold_valid_ff;
      if (load) begin
         hold_valid_in = 1'b1;
      end else if (drain) begin
         hold_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_valid_ff <= 1'b0;
      end else begin
         hold_valid_ff <= hold_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         hold_ff <= snap_data;
      end
   end

   sprf_fifo #(
      .WIDTH ($bits(sprf_rsp_type)),
      .DEPTH (RSP_DEPTH)
   ) u_rsp_fifo (
      .clock (clock),
      .reset (reset),
      .push  (hold_valid_ff),
      .wdata (result),
      .full  (out_full),
      .pop   (rsp_pop),
      .rdata (out_rdata),
      .empty (rsp_empty)
   );

   assign rsp_data = sprf_rsp_type'(out_rdata);

endmodule

FILE: hdl/smallest_padding_run_finder.sv
// Path: a result shows on the rsp_ ports once the last byte of an image has passed the item
// queue, the run tracker into the hold register and the growth stage into the result queue.
// A full result queue keeps a result in the hold register, stalling the run tracker.
// Throughput: one byte per cycle if not stalled; runs close and the best updates per byte.
// Reset: synchronous, active high; clears all queues and search state and loads
// min_run_len 1, required_attributes 0, grow_align 4096. No clearing pass.
module smallest_padding_run_finder
   import sprf_pkg::*;
#(
   parameter int QUEUE_DEPTH = 4,
   parameter int RSP_DEPTH   = 2
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_push,
   output logic                   req_full,
   input  sprf_req_type           req_data,
   output logic                   rsp_empty,
   input  logic                   rsp_pop,
   output sprf_rsp_type           rsp_data,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [31:0]            csr_data
);

   sprf_cfg_type  cfg_ff, cfg_in;
   logic          queue_push;
   logic          queue_full;
   logic          queue_empty;
   logic          queue_pop;
   sprf_item_type queue_item;
   sprf_item_type back_item;
   logic [$bits(sprf_item_type)-1:0] queue_rdata;
   logic          snap_valid;
   logic          snap_ready;
   sprf_best_type snap_data;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_MIN_RUN_LEN:         cfg_in.min_run_len         = csr_data;
            CSR_REQUIRED_ATTRIBUTES: cfg_in.required_attributes = csr_data;
            CSR_GROW_ALIGN:          cfg_in.align_mask          = csr_data - 32'd1;
            default:                 cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.min_run_len         <= RESET_MIN_RUN_LEN;
         cfg_ff.required_attributes <= RESET_REQUIRED_ATTRIBUTES;
         cfg_ff.align_mask          <= RESET_ALIGN_MASK;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   sprf_front u_front (
      .req_push   (req_push),
      .req_data   (req_data),
      .req_full   (req_full),
      .cfg        (cfg_ff),
      .queue_full (queue_full),
      .queue_push (queue_push),
      .queue_item (queue_item)
   );

   sprf_fifo #(
      .WIDTH ($bits(sprf_item_type)),
      .DEPTH (QUEUE_DEPTH)
   ) u_item_fifo (
      .clock (clock),
      .reset (reset),
      .push  (queue_push),
      .wdata (queue_item),
      .full  (queue_full),
      .pop   (queue_pop),
      .rdata (queue_rdata),
      .empty (queue_empty)
   );

   assign back_item = sprf_item_type'(queue_rdata);

   sprf_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .item_valid (!queue_empty),
      .item       (back_item),
      .item_pop   (queue_pop),
      .snap_valid (snap_valid),
      .snap_ready (snap_ready),
      .snap_data  (snap_data)
   );

   sprf_finish #(
      .RSP_DEPTH (RSP_DEPTH)
   ) u_finish (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .snap_valid (snap_valid),
      .snap_ready (snap_ready),
      .snap_data  (snap_data),
      .rsp_pop    (rsp_pop),
      .rsp_empty  (rsp_empty),
      .rsp_data   (rsp_data)
   );

endmodule

FILE: hdl/sprf_checker.sv
`include "smallest_padding_run_finder_defines.svh"

module sprf_checker
   import sprf_pkg::*;
(
   input logic         clock,
   input logic         reset,
   input logic         rsp_empty,
   input logic         rsp_pop,
   input sprf_rsp_type rsp_data
);

   `SPRF_ASSERT_IMPLY(a_empty_after_reset, clock, reset, $past(reset), rsp_empty, "result waiting right after reset")
   `SPRF_ASSERT_IMPLY(a_miss_is_zero, clock, reset, !rsp_empty && !rsp_data.found, rsp_data == '0, "result without a cave has nonzero fields")
   `SPRF_ASSERT_NEVER(a_found_has_length, clock, reset, !rsp_empty && rsp_data.found && rsp_data.cave_length == '0, "found cave of zero length")
   `SPRF_ASSERT_NEXT(a_rsp_holds, clock, reset, !rsp_empty && !rsp_pop, !rsp_empty && $stable(rsp_data), "waiting result changed before transfer")

endmodule

bind smallest_padding_run_finder sprf_checker u_checker (.*);

FILE: verif/tb.sv
module tb;
   import sprf_pkg::*;

   typedef struct packed {
      sprf_req_type item;
      logic         typed;
      sprf_rsp_type cave;
   } directed_row_type;

   localparam sprf_rsp_type NO_CAVE = '0;
   localparam int DIRECTED_ROWS = 18;
   localparam int PHASE_BYTES = 84;

   localparam directed_row_type DIRECTED [DIRECTED_ROWS] = '{
      '{'{8'hFF, 7'd0, 32'h0, 32'h0, 1'b1, 1'b1}, 1'b1, NO_CAVE},
      '{'{FILL_TRAP, 7'd127, ALL_ONES, 32'h0, 1'b1, 1'b1}, 1'b1,
        '{1'b1, 7'd127, 32'd0, 32'd1, 1'b1, 32'd4096}},
      '{'{FILL_ZERO, 7'd0, 32'h0, ALL_ONES, 1'b0, 1'b1}, 1'b1,
        '{1'b1, 7'd0, 32'd0, 32'd1, 1'b0, ALL_ONES}},
      '{'{FILL_ZERO, 7'd3, 32'h1234_5678, 32'd2, 1'b0, 1'b0}, 1'b0, NO_CAVE},
      '{'{FILL_ZERO, 7'd3, 32'h1234_5678, 32'd2, 1'b0, 1'b0}, 1'b0, NO_CAVE},
      '{'{FILL_TRAP, 7'd3, 32'h1234_5678, 32'd2, 1'b0, 1'b0}, 1'b0, NO_CAVE},
      '{'{FILL_TRAP, 7'd3, 32'h1234_5678, 32'd2, 1'b0, 1'b0}, 1'b0, NO_CAVE},
      '{'{FILL_TRAP, 7'd3, 32'h1234_5678, 32'd2, 1'b0, 1'b0}, 1'b0, NO_CAVE},
      '{'{FILL_ZERO, 7'd3, 32'h1234_5678, 32'd2, 1'b0, 1'b0}, 1'b0, NO_CAVE},
      '{'{8'hFF, 7'd3, 32'h1234_5678, 32'd2, 1'b0, 1'b0}, 1'b0, NO_CAVE},
      '{'{FILL_ZERO, 7'd3, 32'h1234_5678, 32'd2, 1'b1, 1'b0}, 1'b0, NO_CAVE},
      '{'{FILL_TRAP, 7'd4, 32'h0, 32'd100, 1'b0, 1'b0}, 1'b0, NO_CAVE},
      '{'{FILL_TRAP, 7'd4, 32'h0, 32'd100, 1'b0, 1'b0}, 1'b0, NO_CAVE},
      '{'{FILL_TRAP, 7'd5, 32'h8000_0000, 32'd7, 1'b0, 1'b0}, 1'b0, NO_CAVE},
      '{'{FILL_ZERO, 7'd5, 32'h8000_0000, 32'd7, 1'b1, 1'b1}, 1'b0, NO_CAVE},
      '{'{8'h01, 7'd1, 32'h5555_AAAA, 32'd0, 1'b0, 1'b0}, 1'b0, NO_CAVE},
      '{'{FILL_TRAP, 7'd1, 32'h5555_AAAA, 32'd0, 1'b0, 1'b0}, 1'b0, NO_CAVE},
      '{'{FILL_TRAP, 7'd1, 32'h5555_AAAA, 32'd0, 1'b0, 1'b1}, 1'b0, NO_CAVE}
   };

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_push = 1'b0;
   logic                   req_full;
   sprf_req_type           req_data = '0;
   logic                   rsp_empty;
   logic                   rsp_pop = 1'b0;
   sprf_rsp_type           rsp_data;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = CSR_MIN_RUN_LEN;
   logic [31:0]            csr_data = '0;

   int send_idle_pct = 18;
   int recv_idle_pct = 66;
   int error_count = 0;

   logic [31:0]   cfg_min_len = RESET_MIN_RUN_LEN;
   logic [31:0]   cfg_attr_mask = RESET_REQUIRED_ATTRIBUTES;
   logic [31:0]   cfg_align = 32'd4096;
   logic [31:0]   scan_offset;
   sprf_run_type  trail;
   sprf_best_type shortest;
   sprf_rsp_type  expected_caves [$];

   smallest_padding_run_finder DUT (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_data  (req_data),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   always #4 clock = ~clock;

   function automatic void restart_search();
      scan_offset = '0;
      trail = RUN_CLEAR;
      shortest = BEST_CLEAR;
   endfunction

   function automatic void close_trail();
      if (trail.active && trail.length >= cfg_min_len && trail.length < shortest.length) begin
         shortest.have    = 1'b1;
         shortest.length  = trail.length;
         shortest.offset  = trail.start;
         shortest.section = trail.section;
         shortest.vsize   = trail.vsize;
      end
      trail.active = 1'b0;
   endfunction

   task automatic track_byte(input sprf_req_type b, output logic done,
                             output sprf_rsp_type cave);
      logic        taken;
      logic        pad;
      logic [31:0] cave_end;
      taken = cfg_attr_mask == '0 || (b.section_attributes & cfg_attr_mask) == cfg_attr_mask;
      pad = taken && (b.data_byte == FILL_ZERO || b.data_byte == FILL_TRAP);
      if (trail.active && (!pad || b.data_byte != trail.value))
         close_trail();
      if (pad) begin
         if (!trail.active) begin
            trail.active  = 1'b1;
            trail.value   = b.data_byte;
            trail.start   = scan_offset;
            trail.length  = '0;
            trail.section = b.section_index;
            trail.vsize   = b.section_virtual_size;
         end
         if (trail.length != ALL_ONES)
            trail.length = trail.length + 32'd1;
      end
      if (b.last_of_section || b.last_of_image) begin
         close_trail();
         scan_offset = '0;
      end else begin
         scan_offset = scan_offset + 32'd1;
      end
      done = b.last_of_image;
      cave = NO_CAVE;
      if (done) begin
         if (shortest.have) begin
            cave_end = shortest.offset + cfg_min_len;
            cave.found            = 1'b1;
            cave.cave_section     = shortest.section;
            cave.cave_start       = shortest.offset;
            cave.cave_length      = shortest.length;
            cave.needs_growth     = cave_end > shortest.vsize;
            cave.new_virtual_size = cave.needs_growth ?
               (cave_end + cfg_align - 32'd1) & ~(cfg_align - 32'd1) : shortest.vsize;
         end
         restart_search();
      end
   endtask

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      error_count++;
      $display("tb: %s mismatch: got %0h, expected %0h", what, got, want);
   endtask

   always @(posedge clock) begin
      sprf_rsp_type want;
      if (!reset) begin
         if (rsp_pop && !rsp_empty) begin
            if (expected_caves.size() == 0) begin
               report_mismatch("unexpected transfer, cave_start", rsp_data.cave_start, '0);
            end else begin
               want = expected_caves.pop_front();
               if (rsp_data.found !== want.found)
                  report_mismatch("found", 32'(rsp_data.found), 32'(want.found));
               if (rsp_data.cave_section !== want.cave_section)
                  report_mismatch("cave_section", 32'(rsp_data.cave_section),
                                  32'(want.cave_section));
               if (rsp_data.cave_start !== want.cave_start)
                  report_mismatch("cave_start", rsp_data.cave_start, want.cave_start);
               if (rsp_data.cave_length !== want.cave_length)
                  report_mismatch("cave_length", rsp_data.cave_length, want.cave_length);
               if (rsp_data.needs_growth !== want.needs_growth)
                  report_mismatch("needs_growth", 32'(rsp_data.needs_growth),
                                  32'(want.needs_growth));
               if (rsp_data.new_virtual_size !== want.new_virtual_size)
                  report_mismatch("new_virtual_size", rsp_data.new_virtual_size,
                                  want.new_virtual_size);
            end
         end
         rsp_pop <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
   end

   task automatic push_byte(input sprf_req_type b, input logic typed,
                            input sprf_rsp_type typed_cave);
      logic         done;
      sprf_rsp_type cave;
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_push <= 1'b0;
         @(posedge clock);
      end
      req_push <= 1'b1;
      req_data <= b;
      do @(posedge clock); while (req_full);
      track_byte(b, done, cave);
      if (done)
         expected_caves.push_back(typed ? typed_cave : cave);
   endtask

   // hold the sender until every cave is back, then let the pipeline settle
   task automatic drain_results();
      req_push <= 1'b0;
      do @(posedge clock); while (expected_caves.size() != 0);
      repeat (10) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx, input logic [31:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_MIN_RUN_LEN:         cfg_min_len = value;
         CSR_REQUIRED_ATTRIBUTES: cfg_attr_mask = value;
         CSR_GROW_ALIGN:          cfg_align = value;
         default: ;
      endcase
   endtask

   function automatic logic [7:0] pick_byte();
      case ($urandom_range(0, 4))
         0, 1:    return FILL_ZERO;
         2, 3:    return FILL_TRAP;
         default: return 8'($urandom);
      endcase
   endfunction

   task automatic send_image(inout int sent);
      int           nsec;
      int           len;
      logic         noisy;
      logic [7:0]   fill;
      sprf_req_type b;
      noisy = $urandom_range(0, 99) < 15;
      nsec = $urandom_range(1, 3);
      for (int s = 0; s < nsec; s++) begin
         b.section_index = 7'($urandom_range(0, 127));
         case ($urandom_range(0, 4))
            0, 1, 2: b.section_attributes = cfg_attr_mask | $urandom;
            3:       b.section_attributes = $urandom;
            default: b.section_attributes = cfg_attr_mask & ~(32'd1 << $urandom_range(0, 31));
         endcase
         case ($urandom_range(0, 5))
            0, 1, 2: b.section_virtual_size = $urandom_range(0, 16);
            3:       b.section_virtual_size = $urandom;
            4:       b.section_virtual_size = '0;
            default: b.section_virtual_size = ALL_ONES;
         endcase
         len = $urandom_range(1, 8);
         fill = pick_byte();
         for (int i = 0; i < len; i++) begin
            if ($urandom_range(0, 99) < 35)
               fill = pick_byte();
            b.data_byte = fill;
            b.last_of_section = (i == len - 1);
            b.last_of_image = (s == nsec - 1) && (i == len - 1);
            if (noisy) begin
               if ($urandom_range(0, 1) == 0)
                  b.data_byte = 8'($urandom);
               b.last_of_section = $urandom_range(0, 3) == 0;
               if (!b.last_of_image)
                  b.last_of_image = $urandom_range(0, 19) == 0;
            end
            push_byte(b, 1'b0, NO_CAVE);
            sent++;
         end
      end
      if ($urandom_range(0, 99) < 8)
         drain_results();
   endtask

   task automatic run_phase(input logic [31:0] min_len, input logic [31:0] attr_mask,
                            input logic [31:0] align, input int mode);
      int sent;
      drain_results();
      write_reg(CSR_MIN_RUN_LEN, min_len);
      write_reg(CSR_REQUIRED_ATTRIBUTES, attr_mask);
      write_reg(CSR_GROW_ALIGN, align);
      csr_valid <= 1'b0;
      case (mode)
         0: begin
            send_idle_pct = 18;
            recv_idle_pct = 66;
         end
         1: begin
            send_idle_pct = 66;
            recv_idle_pct = 18;
         end
         default: begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
      endcase
      sent = 0;
      while (sent < PHASE_BYTES)
         send_image(sent);
   endtask

   initial begin
      restart_search();
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      for (int i = 0; i < DIRECTED_ROWS; i++)
         push_byte(DIRECTED[i].item, DIRECTED[i].typed, DIRECTED[i].cave);
      run_phase(32'd2, 32'd0, 32'd1, 0);
      run_phase(32'd0, 32'h0000_0005, 32'h8000_0000, 0);
      run_phase(ALL_ONES, ALL_ONES, 32'd16, 1);
      run_phase($urandom_range(3, 6), 32'h0000_0100 | $urandom_range(0, 15),
                $urandom_range(1, 100), 1);
      run_phase(32'd1, 32'd0, 32'd4096, 2);
      run_phase($urandom_range(1, 4), 32'h8000_0001, 32'd256, 2);
      drain_results();
      if (error_count == 0)
         $display("tb: clean");
      else
         $display("tb: errors");
      $finish;
   end

   initial begin
      #(8 * 500000);
      $display("tb: errors");
      $finish;
   end

endmodule
